### rtl/lmt_pkg.sv
// Shared types and constants of the LCD mode timing controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lmt_pkg;

  // Dot counter width and palette register count
  localparam int unsigned DOT_W = 10;
  localparam int unsigned PAL_N = 5;

  // Request operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register offsets
  localparam logic [3:0] REG_CTRL      = 4'd0;
  localparam logic [3:0] REG_STATUS    = 4'd1;
  localparam logic [3:0] REG_SCY       = 4'd2;
  localparam logic [3:0] REG_SCX       = 4'd3;
  localparam logic [3:0] REG_LY        = 4'd4;
  localparam logic [3:0] REG_LYC       = 4'd5;
  localparam logic [3:0] REG_PAL_FIRST = 4'd7;
  localparam logic [3:0] REG_PAL_LAST  = 4'd11;

  // Display modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // STAT interrupt flag actions
  localparam logic [1:0] STAT_NONE  = 2'd0;
  localparam logic [1:0] STAT_SET   = 2'd1;
  localparam logic [1:0] STAT_CLEAR = 2'd2;

  // Fixed status write mask and timing constants
  localparam logic [7:0]       STAT_WRITE_MASK = 8'h78;
  localparam logic [7:0]       LINE_VBLANK     = 8'd144;
  localparam logic [7:0]       LINE_WRAP       = 8'd154;
  localparam logic [DOT_W-1:0] HBLANK_FINE_LO  = 10'd200;
  localparam logic [DOT_W-1:0] HBLANK_FINE_HI  = 10'd196;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       vblank_request;
    logic [1:0] stat_action;
    logic       frame_ready;
    logic [1:0] current_mode;
  } res_t;

  typedef struct packed {
    logic [7:0]             ctrl;
    logic [7:0]             stat;
    logic [7:0]             scy;
    logic [7:0]             scx;
    logic [7:0]             ly;
    logic [7:0]             lyc;
    logic [PAL_N-1:0][7:0]  pal;
    logic [1:0]             mode;
    logic [DOT_W-1:0]       dots;
  } state_t;

endpackage

### rtl/lmt_engine.sv
// Next-state and result logic for one request of the LCD mode timing controller.
// Depends on lmt_pkg; purely combinational.
`timescale 1ns / 1ps

module lmt_engine #(
  parameter int unsigned HBLANK_DOTS      = 204,
  parameter int unsigned VBLANK_LINE_DOTS = 456,
  parameter int unsigned OAM_SCAN_DOTS    = 80,
  parameter int unsigned TRANSFER_DOTS    = 172
) (
  input  lmt_pkg::state_t cur,
  input  lmt_pkg::cmd_t   cmd,
  output lmt_pkg::state_t nxt,
  output lmt_pkg::res_t   result
);
  import lmt_pkg::*;

  localparam logic [DOT_W-1:0] HBLANK_LEN = DOT_W'(HBLANK_DOTS);
  localparam logic [DOT_W-1:0] VBLANK_LEN = DOT_W'(VBLANK_LINE_DOTS);
  localparam logic [DOT_W-1:0] OAM_LEN    = DOT_W'(OAM_SCAN_DOTS);
  localparam logic [DOT_W-1:0] XFER_LEN   = DOT_W'(TRANSFER_DOTS);

  // STAT source check for a given mode and status value
  function automatic logic [1:0] stat_eval(input logic [1:0] mode, input logic [7:0] stat);
    logic hit;
    begin
      hit = (mode == MODE_HBLANK && stat[3]) ||
            (mode == MODE_VBLANK && stat[4]) ||
            (mode == MODE_OAM    && stat[5]) ||
            (mode == MODE_XFER   && stat[6]) ||
            (stat[2] && stat[6]);
      return hit ? STAT_SET : STAT_CLEAR;
    end
  endfunction

  logic             lcd_on;
  logic [DOT_W-1:0] dots_inc;
  logic [DOT_W-1:0] hblank_len;
  logic [7:0]       ly_inc;
  logic [2:0]       pal_idx;
  logic [7:0]       stat_wr;

  assign lcd_on   = cur.ctrl[7];
  assign dots_inc = cur.dots + DOT_W'(1);
  assign ly_inc   = cur.ly + 8'd1;
  assign pal_idx  = 3'(cmd.reg_offset - REG_PAL_FIRST);
  assign stat_wr  = cmd.write_data & STAT_WRITE_MASK;

  // Pick hblank length from the fine scroll
  always_comb begin
    if (cur.scx[2:0] == 3'd0) begin
      hblank_len = HBLANK_LEN;
    end else if (cur.scx[2:0] <= 3'd4) begin
      hblank_len = HBLANK_FINE_LO;
    end else begin
      hblank_len = HBLANK_FINE_HI;
    end
  end

  // Evaluate the request against the current state
  always_comb begin
    nxt    = cur;
    result = '0;
    case (cmd.operation)
      OP_TICK: begin
        if (lcd_on) begin
          nxt.dots = dots_inc;
          case (cur.mode)
            MODE_HBLANK: begin
              if (dots_inc >= hblank_len) begin
                nxt.dots = dots_inc - hblank_len;
                nxt.ly   = ly_inc;
                if (ly_inc == LINE_VBLANK) begin
                  nxt.mode              = MODE_VBLANK;
                  nxt.stat[1:0]         = MODE_VBLANK;
                  result.vblank_request = 1'b1;
                  result.frame_ready    = 1'b1;
                end else begin
                  nxt.mode           = MODE_OAM;
                  nxt.stat[1:0]      = MODE_OAM;
                  result.stat_action = stat_eval(MODE_OAM, cur.stat);
                end
              end
            end
            MODE_VBLANK: begin
              if (dots_inc >= VBLANK_LEN) begin
                nxt.dots = dots_inc - VBLANK_LEN;
                if (ly_inc == LINE_WRAP) begin
                  nxt.ly             = 8'd0;
                  nxt.mode           = MODE_OAM;
                  nxt.stat[1:0]      = MODE_OAM;
                  result.stat_action = stat_eval(MODE_OAM, cur.stat);
                end else begin
                  nxt.ly             = ly_inc;
                  result.stat_action = stat_eval(MODE_VBLANK, cur.stat);
                end
              end
            end
            MODE_OAM: begin
              if (dots_inc >= OAM_LEN) begin
                nxt.dots      = dots_inc - OAM_LEN;
                nxt.mode      = MODE_XFER;
                nxt.stat[1:0] = MODE_XFER;
              end
            end
            default: begin
              if (dots_inc >= XFER_LEN) begin
                nxt.dots           = dots_inc - XFER_LEN;
                nxt.mode           = MODE_HBLANK;
                nxt.stat[1:0]      = MODE_HBLANK;
                result.stat_action = stat_eval(MODE_HBLANK, cur.stat);
              end
            end
          endcase
        end
      end
      OP_READ: begin
        case (cmd.reg_offset)
          REG_CTRL:   result.read_data = cur.ctrl;
          REG_STATUS: result.read_data = cur.stat;
          REG_SCY:    result.read_data = cur.scy;
          REG_SCX:    result.read_data = cur.scx;
          REG_LY:     result.read_data = cur.ly;
          REG_LYC:    result.read_data = cur.lyc;
          default: begin
            if (cmd.reg_offset inside {[REG_PAL_FIRST:REG_PAL_LAST]}) begin
              result.read_data = cur.pal[pal_idx];
            end
          end
        endcase
      end
      OP_WRITE: begin
        case (cmd.reg_offset)
          REG_CTRL: begin
            nxt.ctrl = cmd.write_data;
            if (lcd_on && !cmd.write_data[7]) begin
              // Display off: drop to hblank on line zero
              nxt.mode      = MODE_HBLANK;
              nxt.stat[1:0] = MODE_HBLANK;
              nxt.ly        = 8'd0;
            end else if (!lcd_on && cmd.write_data[7]) begin
              // Display on: restart at OAM scan, LYC check has the last word
              nxt.mode           = MODE_OAM;
              nxt.stat[1:0]      = MODE_OAM;
              nxt.dots           = '0;
              result.stat_action = (cur.ly == cur.lyc) ? STAT_SET : STAT_CLEAR;
            end
          end
          REG_STATUS: begin
            nxt.stat = stat_wr;
            if (lcd_on) begin
              result.stat_action = stat_eval(cur.mode, stat_wr);
            end
          end
          REG_SCY: nxt.scy = cmd.write_data;
          REG_SCX: nxt.scx = cmd.write_data;
          REG_LY:  nxt.ly  = cmd.write_data;
          REG_LYC: begin
            nxt.lyc = cmd.write_data;
            if (lcd_on) begin
              result.stat_action = (cur.ly == cmd.write_data) ? STAT_SET : STAT_CLEAR;
            end
          end
          default: begin
            if (cmd.reg_offset inside {[REG_PAL_FIRST:REG_PAL_LAST]}) begin
              nxt.pal[pal_idx] = cmd.write_data;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
    result.current_mode = nxt.mode;
  end

endmodule

### rtl/lmt_state.sv
// Display registers, line counter, mode and dot counter of the LCD timing block.
// Depends on lmt_pkg; loads the next state when a request is evaluated.
`timescale 1ns / 1ps

module lmt_state (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  lmt_pkg::state_t state_next,
  output lmt_pkg::state_t state
);
  import lmt_pkg::*;

  // Clear everything on reset, advance on each evaluated request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (load) begin
      state <= state_next;
    end
  end

endmodule

### rtl/lcd_mode_timing_controller_core.sv
// Top level of the LCD mode timing controller: request register, state, result register.
// Depends on lmt_pkg, lmt_engine and lmt_state.
`timescale 1ns / 1ps

// Takes one request per clock (dot tick, register read or register write) and
// returns exactly one result per request, in order. An accepted request is held
// in the request register and evaluated combinationally against the display
// state; its result is loaded into the result register when the result slot
// is free or draining. Sustained throughput is one request per cycle while
// results are taken as they appear. The rate is set by the state update loop
// (dot counter compare, subtract and mode change). A result waiting for
// res_ready stalls evaluation, and the request register fills before cmd_ready
// drops.
module lcd_mode_timing_controller_core #(
  parameter int unsigned HBLANK_DOTS      = 204,
  parameter int unsigned VBLANK_LINE_DOTS = 456,
  parameter int unsigned OAM_SCAN_DOTS    = 80,
  parameter int unsigned TRANSFER_DOTS    = 172
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  lmt_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output lmt_pkg::res_t res
);
  import lmt_pkg::*;

  logic   pend_valid;
  cmd_t   pend;
  logic   advance;
  state_t state;
  state_t state_next;
  res_t   result;

  // Evaluate when a request is held and the result slot is free or draining
  assign advance   = pend_valid && (!res_valid || res_ready);
  assign cmd_ready = !pend_valid || advance;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd_ready) begin
      pend_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      pend <= cmd;
    end
  end

  lmt_engine #(
    .HBLANK_DOTS      (HBLANK_DOTS),
    .VBLANK_LINE_DOTS (VBLANK_LINE_DOTS),
    .OAM_SCAN_DOTS    (OAM_SCAN_DOTS),
    .TRANSFER_DOTS    (TRANSFER_DOTS)
  ) u_engine (
    .cur    (state),
    .cmd    (pend),
    .nxt    (state_next),
    .result (result)
  );

  lmt_state u_state (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .state_next (state_next),
    .state      (state)
  );

  // Register the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= result;
    end
  end

endmodule

### tb/tb.sv
// Self-checking testbench for lcd_mode_timing_controller_core.
// Depends on lmt_pkg and the core; a shadow copy of the display state predicts each result.
`timescale 1ns / 1ps

module tb;
  import lmt_pkg::*;

  localparam int unsigned HBLANK_DOTS      = 204;
  localparam int unsigned VBLANK_LINE_DOTS = 456;
  localparam int unsigned OAM_SCAN_DOTS    = 80;
  localparam int unsigned TRANSFER_DOTS    = 172;

  // Operation code with no effect on the display
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam logic [3:0] REG_UNMAPPED_LO = 4'd6;
  localparam logic [3:0] REG_UNMAPPED_HI = 4'd15;
  localparam logic [3:0] REG_PAST_PAL    = 4'd12;

  localparam int unsigned RANDOM_ITEMS   = 480;
  localparam int unsigned PHASES         = 4;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    cmd_t c;
    logic typed;
    res_t r;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  // Shadow display state
  logic [7:0]       shadow_ctrl, shadow_stat, shadow_scy, shadow_scx;
  logic [7:0]       shadow_ly, shadow_lyc;
  logic [7:0]       shadow_pal [PAL_N];
  logic [1:0]       shadow_mode;
  logic [DOT_W-1:0] shadow_dots;

  res_t        results_due [$];
  res_t        head_result;
  stim_row_t   stim_table [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fault_count = 0;
  int unsigned results_checked = 0;
  int unsigned requests_sent = 0;
  int unsigned vblank_entries = 0;
  int unsigned frame_wraps = 0;
  int unsigned quiet_cycles = 0;

  lcd_mode_timing_controller_core #(
    .HBLANK_DOTS     (HBLANK_DOTS),
    .VBLANK_LINE_DOTS(VBLANK_LINE_DOTS),
    .OAM_SCAN_DOTS   (OAM_SCAN_DOTS),
    .TRANSFER_DOTS   (TRANSFER_DOTS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // STAT interrupt check on the shadow state
  function automatic logic [1:0] stat_irq_action();
    logic hit;
    hit = (shadow_mode == MODE_HBLANK && shadow_stat[3]) ||
          (shadow_mode == MODE_VBLANK && shadow_stat[4]) ||
          (shadow_mode == MODE_OAM    && shadow_stat[5]) ||
          (shadow_mode == MODE_XFER   && shadow_stat[6]) ||
          (shadow_stat[2] && shadow_stat[6]);
    return hit ? STAT_SET : STAT_CLEAR;
  endfunction

  function automatic logic [1:0] lyc_irq_action();
    return (shadow_ly == shadow_lyc) ? STAT_SET : STAT_CLEAR;
  endfunction

  // Enter a mode and mirror it into the low status bits
  task automatic switch_mode(input logic [1:0] m);
    shadow_mode = m;
    shadow_stat = {shadow_stat[7:2], m};
  endtask

  task automatic reset_shadow();
    shadow_ctrl = '0;
    shadow_stat = '0;
    shadow_scy  = '0;
    shadow_scx  = '0;
    shadow_ly   = '0;
    shadow_lyc  = '0;
    for (int i = 0; i < PAL_N; i++) shadow_pal[i] = '0;
    shadow_mode = MODE_HBLANK;
    shadow_dots = '0;
  endtask

  // Advance the shadow state by one request and form its result
  task automatic predict_display(input cmd_t c, output res_t r);
    logic [7:0]  rd;
    logic [1:0]  act;
    logic        vbl;
    logic        frm;
    logic        was_on;
    int unsigned len;
    rd  = '0;
    act = STAT_NONE;
    vbl = 1'b0;
    frm = 1'b0;
    case (c.operation)
      OP_TICK: begin
        if (shadow_ctrl[7]) begin
          shadow_dots = shadow_dots + 1'b1;
          case (shadow_mode)
            MODE_HBLANK: begin
              case (shadow_scx[2:0])
                3'd0: len = HBLANK_DOTS;
                3'd1, 3'd2, 3'd3, 3'd4: len = HBLANK_FINE_LO;
                default: len = HBLANK_FINE_HI;
              endcase
              if (shadow_dots >= len) begin
                shadow_dots = shadow_dots - len[DOT_W-1:0];
                shadow_ly = shadow_ly + 8'd1;
                if (shadow_ly == LINE_VBLANK) begin
                  switch_mode(MODE_VBLANK);
                  vbl = 1'b1;
                  frm = 1'b1;
                  vblank_entries++;
                end else begin
                  switch_mode(MODE_OAM);
                  act = stat_irq_action();
                end
              end
            end
            MODE_VBLANK: begin
              if (shadow_dots >= VBLANK_LINE_DOTS) begin
                shadow_dots = shadow_dots - VBLANK_LINE_DOTS[DOT_W-1:0];
                shadow_ly = shadow_ly + 8'd1;
                // LYC check runs first, the STAT check after it wins
                act = lyc_irq_action();
                act = stat_irq_action();
                if (shadow_ly == LINE_WRAP) begin
                  switch_mode(MODE_OAM);
                  act = lyc_irq_action();
                  act = stat_irq_action();
                  shadow_ly = '0;
                  frame_wraps++;
                end
              end
            end
            MODE_OAM: begin
              if (shadow_dots >= OAM_SCAN_DOTS) begin
                shadow_dots = shadow_dots - OAM_SCAN_DOTS[DOT_W-1:0];
                switch_mode(MODE_XFER);
              end
            end
            default: begin
              if (shadow_dots >= TRANSFER_DOTS) begin
                shadow_dots = shadow_dots - TRANSFER_DOTS[DOT_W-1:0];
                switch_mode(MODE_HBLANK);
                act = stat_irq_action();
              end
            end
          endcase
        end
      end
      OP_READ: begin
        case (c.reg_offset)
          REG_CTRL:   rd = shadow_ctrl;
          REG_STATUS: rd = shadow_stat;
          REG_SCY:    rd = shadow_scy;
          REG_SCX:    rd = shadow_scx;
          REG_LY:     rd = shadow_ly;
          REG_LYC:    rd = shadow_lyc;
          default: begin
            if (c.reg_offset >= REG_PAL_FIRST && c.reg_offset <= REG_PAL_LAST)
              rd = shadow_pal[3'(c.reg_offset - REG_PAL_FIRST)];
          end
        endcase
      end
      OP_WRITE: begin
        case (c.reg_offset)
          REG_CTRL: begin
            was_on = shadow_ctrl[7];
            shadow_ctrl = c.write_data;
            if (was_on && !c.write_data[7]) begin
              switch_mode(MODE_HBLANK);
              shadow_ly = '0;
            end else if (!was_on && c.write_data[7]) begin
              switch_mode(MODE_OAM);
              act = stat_irq_action();
              act = lyc_irq_action();
              shadow_dots = '0;
            end
          end
          REG_STATUS: begin
            shadow_stat = c.write_data & STAT_WRITE_MASK;
            if (shadow_ctrl[7]) act = stat_irq_action();
          end
          REG_SCY: shadow_scy = c.write_data;
          REG_SCX: shadow_scx = c.write_data;
          REG_LY:  shadow_ly  = c.write_data;
          REG_LYC: begin
            shadow_lyc = c.write_data;
            if (shadow_ctrl[7]) begin
              act = stat_irq_action();
              act = lyc_irq_action();
            end
          end
          default: begin
            if (c.reg_offset >= REG_PAL_FIRST && c.reg_offset <= REG_PAL_LAST)
              shadow_pal[3'(c.reg_offset - REG_PAL_FIRST)] = c.write_data;
          end
        endcase
      end
      default: ;
    endcase
    r.read_data      = rd;
    r.vblank_request = vbl;
    r.stat_action    = act;
    r.frame_ready    = frm;
    r.current_mode   = shadow_mode;
  endtask

  task automatic add_row(input logic [1:0] op, input logic [3:0] off, input logic [7:0] d,
                         input logic typed, input logic [7:0] rd);
    stim_row_t row;
    row.c.operation  = op;
    row.c.reg_offset = off;
    row.c.write_data = d;
    row.typed        = typed;
    row.r            = '0;
    row.r.read_data  = rd;
    row.r.current_mode = MODE_HBLANK;
    stim_table.push_back(row);
  endtask

  // Present one request, hold it until taken, then log its expected result
  task automatic send_request(input cmd_t c, input logic typed, input res_t typed_res);
    res_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    predict_display(c, pred);
    if (typed) pred = typed_res;
    results_due.push_back(pred);
    requests_sent++;
  endtask

  // Drop valid and hold off until every outstanding result is back
  task automatic drain_results();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Receiver stall
  always @(negedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (results_due.size() == 0) begin
        $error("result with no request outstanding: %h", res);
        fault_count++;
      end else begin
        head_result = results_due.pop_front();
        results_checked++;
        if (res.read_data !== head_result.read_data) begin
          $error("read_data expected %0h got %0h", head_result.read_data, res.read_data);
          fault_count++;
        end
        if (res.vblank_request !== head_result.vblank_request) begin
          $error("vblank_request expected %0b got %0b",
                 head_result.vblank_request, res.vblank_request);
          fault_count++;
        end
        if (res.stat_action !== head_result.stat_action) begin
          $error("stat_action expected %0d got %0d", head_result.stat_action, res.stat_action);
          fault_count++;
        end
        if (res.frame_ready !== head_result.frame_ready) begin
          $error("frame_ready expected %0b got %0b", head_result.frame_ready, res.frame_ready);
          fault_count++;
        end
        if (res.current_mode !== head_result.current_mode) begin
          $error("current_mode expected %0d got %0d",
                 head_result.current_mode, res.current_mode);
          fault_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    cmd_t        c;
    int unsigned pick;
    int unsigned burst;
    int unsigned phase;
    int unsigned directed_count;
    int unsigned left;
    reset_shadow();

    // Directed table: reset values, unmapped offsets and no-op first, all with display off
    add_row(OP_READ,  REG_CTRL,        8'h00, 1'b1, 8'h00);
    add_row(OP_READ,  REG_STATUS,      8'h00, 1'b1, 8'h00);
    add_row(OP_READ,  REG_LY,          8'h00, 1'b1, 8'h00);
    add_row(OP_READ,  REG_UNMAPPED_LO, 8'hFF, 1'b1, 8'h00);
    add_row(OP_READ,  REG_UNMAPPED_HI, 8'hFF, 1'b1, 8'h00);
    add_row(OP_NOP,   REG_UNMAPPED_HI, 8'hFF, 1'b1, 8'h00);
    add_row(OP_TICK,  REG_CTRL,        8'hFF, 1'b1, 8'h00);
    add_row(OP_WRITE, REG_PAL_FIRST,   8'hFF, 1'b0, 8'h00);
    add_row(OP_READ,  REG_PAL_FIRST,   8'h00, 1'b1, 8'hFF);
    add_row(OP_WRITE, REG_PAL_LAST,    8'h5A, 1'b0, 8'h00);
    add_row(OP_READ,  REG_PAL_LAST,    8'h00, 1'b1, 8'h5A);
    add_row(OP_WRITE, REG_PAST_PAL,    8'hFF, 1'b0, 8'h00);
    add_row(OP_READ,  REG_PAST_PAL,    8'h00, 1'b1, 8'h00);
    add_row(OP_WRITE, REG_STATUS,      8'hFF, 1'b0, 8'h00);
    add_row(OP_READ,  REG_STATUS,      8'h00, 1'b1, STAT_WRITE_MASK);
    add_row(OP_WRITE, REG_SCX,         8'hFF, 1'b0, 8'h00);
    add_row(OP_WRITE, REG_SCY,         8'hFF, 1'b0, 8'h00);
    add_row(OP_WRITE, REG_LYC,         8'h00, 1'b0, 8'h00);
    // Display on, the LYC-enable quirk, compare mismatch, off and on again
    add_row(OP_WRITE, REG_CTRL,        8'h80, 1'b0, 8'h00);
    add_row(OP_WRITE, REG_STATUS,      8'h40, 1'b0, 8'h00);
    add_row(OP_WRITE, REG_LYC,         8'h07, 1'b0, 8'h00);
    add_row(OP_WRITE, REG_LY,          LINE_VBLANK - 8'd1, 1'b0, 8'h00);
    add_row(OP_WRITE, REG_CTRL,        8'h00, 1'b0, 8'h00);
    add_row(OP_READ,  REG_LY,          8'h00, 1'b1, 8'h00);
    add_row(OP_WRITE, REG_CTRL,        8'hFF, 1'b0, 8'h00);
    add_row(OP_TICK,  REG_UNMAPPED_HI, 8'h00, 1'b0, 8'h00);
    add_row(OP_WRITE, REG_LY,          8'hFF, 1'b0, 8'h00);
    directed_count = stim_table.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) send_request(stim_table[i].c, stim_table[i].typed, stim_table[i].r);

    // Random part: one register or no-op request, then a burst of dot ticks
    phase = PHASES;
    while (requests_sent < directed_count + RANDOM_ITEMS) begin
      if ((requests_sent - directed_count) * PHASES / RANDOM_ITEMS != phase) begin
        phase = (requests_sent - directed_count) * PHASES / RANDOM_ITEMS;
        drain_results();
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
          default: begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
      end

      c.reg_offset = 4'($urandom_range(0, 15));
      c.write_data = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        c.operation = OP_NOP;
      end else if (pick < 30) begin
        c.operation = OP_READ;
      end else begin
        c.operation = OP_WRITE;
        case ($urandom_range(0, 9))
          0, 1: begin
            // Steer the line counter toward vblank entry, frame wrap and 8-bit wrap
            c.reg_offset = REG_LY;
            if (shadow_mode == MODE_VBLANK)
              c.write_data = 8'($urandom_range(LINE_WRAP - 2, LINE_WRAP - 1));
            else if ($urandom_range(0, 1) == 0)
              c.write_data = LINE_VBLANK - 8'd1;
            else if ($urandom_range(0, 2) == 0)
              c.write_data = 8'($urandom_range(250, 255));
          end
          2: begin
            c.reg_offset = REG_LYC;
            if ($urandom_range(0, 1) == 0) c.write_data = shadow_ly;
          end
          3: c.reg_offset = REG_STATUS;
          4: c.reg_offset = REG_SCX;
          5: begin
            c.reg_offset = REG_CTRL;
            c.write_data[7] = ($urandom_range(0, 99) < 85);
          end
          default: ;
        endcase
      end
      send_request(c, 1'b0, '0);

      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 260) : $urandom_range(0, 12);
      left  = directed_count + RANDOM_ITEMS - requests_sent;
      if (burst > left) burst = left;
      for (int unsigned k = 0; k < burst; k++) begin
        c.operation  = OP_TICK;
        c.reg_offset = 4'($urandom_range(0, 15));
        c.write_data = 8'($urandom_range(0, 255));
        send_request(c, 1'b0, '0);
      end
    end

    // Let the pipeline empty, then allow a few more cycles for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d from the directed table), compared %0d results.",
             requests_sent, directed_count, results_checked);
    $display("Shadow state saw %0d vblank entries and %0d frame wraps over four stall mixes.",
             vblank_entries, frame_wraps);
    if (fault_count == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### lcd_mode_timing_controller_core.f
rtl/lmt_pkg.sv
rtl/lmt_engine.sv
rtl/lmt_state.sv
rtl/lcd_mode_timing_controller_core.sv
tb/tb.sv
